/* design/mi3inv_pkg.sv */
// ----------------------------------------------------------------------------
// mi3inv_pkg
// Types, constants and the divider step shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package mi3inv_pkg;

  localparam int unsigned ElemW     = 16;
  localparam int unsigned ProdW     = 2 * ElemW;
  localparam int unsigned CofW      = ProdW + 1;
  localparam int unsigned DetW      = 49;
  localparam int unsigned InvW      = 32;
  localparam int unsigned FracShift = 24;
  localparam int unsigned DivSteps  = InvW;
  localparam int unsigned LaneStages = DivSteps + 1;

  localparam logic [InvW-1:0] InvMax = {1'b0, {(InvW-1){1'b1}}};
  localparam logic [InvW-1:0] InvMin = {1'b1, {(InvW-1){1'b0}}};

  typedef struct packed {
    logic [DetW-1:0] rem;
    logic [InvW-1:0] rest;
    logic [InvW-1:0] quo;
    logic [DetW-1:0] dmag;
    logic            ovf;
    logic            neg;
  } div_stage_t;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  function automatic div_stage_t div_step(div_stage_t s);
    logic [DetW:0] t;
    logic [DetW:0] d;
    logic [DetW:0] diff;
    div_stage_t    r;
    t    = {s.rem, s.rest[InvW-1]};
    d    = {1'b0, s.dmag};
    diff = t - d;
    r    = s;
    if (t >= d) begin
      r.rem = diff[DetW-1:0];
      r.quo = {s.quo[InvW-2:0], 1'b1};
    end else begin
      r.rem = t[DetW-1:0];
      r.quo = {s.quo[InvW-2:0], 1'b0};
    end
    r.rest = {s.rest[InvW-2:0], 1'b0};
    return r;
  endfunction

endpackage

/* design/mi3inv_if.sv */
// ----------------------------------------------------------------------------
// mi3inv_in_if / mi3inv_out_if
// Valid/ready channels for the matrix requests and the inverse results.
// ----------------------------------------------------------------------------
interface mi3inv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mi3inv_pkg::ElemW-1:0]     a00, a01, a02;
  logic signed [mi3inv_pkg::ElemW-1:0]     a10, a11, a12;
  logic signed [mi3inv_pkg::ElemW-1:0]     a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3inv_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [mi3inv_pkg::InvW-1:0]      inv00, inv01, inv02;
  logic signed [mi3inv_pkg::InvW-1:0]      inv10, inv11, inv12;
  logic signed [mi3inv_pkg::InvW-1:0]      inv20, inv21, inv22;
  logic                                    singular;
  logic signed [mi3inv_pkg::DetW-1:0]      det_value;

  modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, det_value, input ready);
  modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, det_value, output ready);
endinterface

/* design/mi3inv_div_lane.sv */
// ----------------------------------------------------------------------------
// mi3inv_div_lane
// Pipelined restoring divider: |cofactor| * 2^24 / |det|, one bit per stage.
// ----------------------------------------------------------------------------
module mi3inv_div_lane (
  input  logic                                    clk_i,
  input  logic [mi3inv_pkg::LaneStages-1:0]       en_i,
  input  logic [mi3inv_pkg::InvW-1:0]             cmag_i,
  input  logic [mi3inv_pkg::DetW-1:0]             dmag_i,
  input  logic                                    neg_i,
  output logic [mi3inv_pkg::InvW-1:0]             quo_o,
  output logic                                    ovf_o,
  output logic                                    neg_o
);

  localparam int unsigned HiW = mi3inv_pkg::InvW - (mi3inv_pkg::InvW - mi3inv_pkg::FracShift);

  mi3inv_pkg::div_stage_t st_q [mi3inv_pkg::LaneStages];
  mi3inv_pkg::div_stage_t init_d;
  logic [mi3inv_pkg::DetW-1:0] hi;

  // dividend bits above the 32 quotient bits form the starting remainder
  always_comb begin
    hi          = {{(mi3inv_pkg::DetW-HiW){1'b0}},
                   cmag_i[mi3inv_pkg::InvW-1:mi3inv_pkg::InvW-HiW]};
    init_d.rem  = hi;
    init_d.rest = {cmag_i[mi3inv_pkg::InvW-HiW-1:0], {mi3inv_pkg::FracShift{1'b0}}};
    init_d.quo  = '0;
    init_d.dmag = dmag_i;
    init_d.ovf  = (hi >= dmag_i);
    init_d.neg  = neg_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_q[0] <= init_d;
    end
  end

  for (genvar k = 1; k < mi3inv_pkg::LaneStages; k++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= mi3inv_pkg::div_step(st_q[k-1]);
      end
    end
  end

  assign quo_o = st_q[mi3inv_pkg::LaneStages-1].quo;
  assign ovf_o = st_q[mi3inv_pkg::LaneStages-1].ovf;
  assign neg_o = st_q[mi3inv_pkg::LaneStages-1].neg;

endmodule

/* design/matrix3x3_inverse.sv */
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Streaming 3x3 inverse by adjugate over determinant, Q8.8 in, Q16.16 out.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  request
//  in_i     in   a00..a22 (16b signed Q8.8)                 one matrix
//  out_o    out  inv00..inv22 (32b Q16.16), singular, det   one inverse
//
//  one request per cycle sustained while out_o is ready; 40 register stages
//  stages: input, products, cofactors, det terms, det, magnitudes, then
//  33 divider stages (one quotient bit per stage) and a saturating output
//  each stage advances when empty or when the one after it advances, so
//  bubbles close up and a stalled result holds without losing requests
//  reset clears the valid bits only
// ----------------------------------------------------------------------------
module matrix3x3_inverse (
  input  logic         clk_i,
  input  logic         rst_ni,
  mi3inv_in_if.sink    in_i,
  mi3inv_out_if.source out_o
);

  localparam int unsigned EW = mi3inv_pkg::ElemW;
  localparam int unsigned PW = mi3inv_pkg::ProdW;
  localparam int unsigned CW = mi3inv_pkg::CofW;
  localparam int unsigned DW = mi3inv_pkg::DetW;
  localparam int unsigned IW = mi3inv_pkg::InvW;
  localparam int unsigned LS = mi3inv_pkg::LaneStages;
  localparam int unsigned SAbs = 5;
  localparam int unsigned SOut = SAbs + LS + 1;
  localparam int unsigned NumStages = SOut + 1;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_i.valid;
      end
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) begin
          v_q[i] <= v_q[i-1];
        end
      end
    end
  end

  // input stage
  logic signed [EW-1:0] a_q [9];
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q[0] <= in_i.a00; a_q[1] <= in_i.a01; a_q[2] <= in_i.a02;
      a_q[3] <= in_i.a10; a_q[4] <= in_i.a11; a_q[5] <= in_i.a12;
      a_q[6] <= in_i.a20; a_q[7] <= in_i.a21; a_q[8] <= in_i.a22;
    end
  end

  // products for the nine 2x2 cofactors, x*y and z*w each
  logic signed [PW-1:0] p_q [18];
  logic signed [EW-1:0] a1_q [3];
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p_q[0]  <= a_q[4] * a_q[8]; p_q[1]  <= a_q[5] * a_q[7];
      p_q[2]  <= a_q[2] * a_q[7]; p_q[3]  <= a_q[1] * a_q[8];
      p_q[4]  <= a_q[1] * a_q[5]; p_q[5]  <= a_q[2] * a_q[4];
      p_q[6]  <= a_q[5] * a_q[6]; p_q[7]  <= a_q[3] * a_q[8];
      p_q[8]  <= a_q[0] * a_q[8]; p_q[9]  <= a_q[2] * a_q[6];
      p_q[10] <= a_q[2] * a_q[3]; p_q[11] <= a_q[0] * a_q[5];
      p_q[12] <= a_q[3] * a_q[7]; p_q[13] <= a_q[4] * a_q[6];
      p_q[14] <= a_q[1] * a_q[6]; p_q[15] <= a_q[0] * a_q[7];
      p_q[16] <= a_q[0] * a_q[4]; p_q[17] <= a_q[1] * a_q[3];
      a1_q[0] <= a_q[0]; a1_q[1] <= a_q[1]; a1_q[2] <= a_q[2];
    end
  end

  logic signed [CW-1:0] adj_q [9];
  logic signed [EW-1:0] a2_q [3];
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < 9; k++) begin
        adj_q[k] <= CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
      end
      a2_q <= a1_q;
    end
  end

  // first-row expansion terms
  logic signed [DW-1:0] term_q [3];
  logic signed [CW-1:0] adj3_q [9];
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      term_q[0] <= DW'(a2_q[0]) * DW'(adj_q[0]);
      term_q[1] <= DW'(a2_q[1]) * DW'(adj_q[3]);
      term_q[2] <= DW'(a2_q[2]) * DW'(adj_q[6]);
      adj3_q    <= adj_q;
    end
  end

  logic signed [DW-1:0] det4_q;
  logic signed [CW-1:0] adj4_q [9];
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det4_q <= term_q[0] + term_q[1] + term_q[2];
      adj4_q <= adj3_q;
    end
  end

  // magnitudes and quotient signs
  logic [IW-1:0] cmag_q [9];
  logic          neg_q  [9];
  logic [DW-1:0] dmag_q;
  logic signed [DW-1:0] det_q  [LS+1];
  logic          sing_q [LS+1];
  always_ff @(posedge clk_i) begin
    if (en[SAbs]) begin
      for (int k = 0; k < 9; k++) begin
        cmag_q[k] <= adj4_q[k][CW-1] ? IW'(-adj4_q[k]) : IW'(adj4_q[k]);
        neg_q[k]  <= adj4_q[k][CW-1] ^ det4_q[DW-1];
      end
      dmag_q    <= det4_q[DW-1] ? DW'(-det4_q) : DW'(det4_q);
      det_q[0]  <= det4_q;
      sing_q[0] <= (det4_q == '0);
    end
  end

  for (genvar j = 1; j <= LS; j++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (en[SAbs+j]) begin
        det_q[j]  <= det_q[j-1];
        sing_q[j] <= sing_q[j-1];
      end
    end
  end

  logic [IW-1:0] quo [9];
  logic          ovf [9];
  logic          qneg [9];
  logic [IW-1:0] inv_d [9];

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3inv_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en[SAbs+LS:SAbs+1]),
      .cmag_i (cmag_q[k]),
      .dmag_i (dmag_q),
      .neg_i  (neg_q[k]),
      .quo_o  (quo[k]),
      .ovf_o  (ovf[k]),
      .neg_o  (qneg[k])
    );
  end

  // sign and saturation to Q16.16
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (sing_q[LS]) begin
        inv_d[k] = '0;
      end else if (!qneg[k]) begin
        inv_d[k] = (ovf[k] || quo[k][IW-1]) ? mi3inv_pkg::InvMax : quo[k];
      end else if (ovf[k] || (quo[k][IW-1] && (|quo[k][IW-2:0]))) begin
        inv_d[k] = mi3inv_pkg::InvMin;
      end else begin
        inv_d[k] = -quo[k];
      end
    end
  end

  logic [IW-1:0]        inv_q [9];
  logic                 sing_out_q;
  logic signed [DW-1:0] det_out_q;
  always_ff @(posedge clk_i) begin
    if (en[SOut]) begin
      inv_q      <= inv_d;
      sing_out_q <= sing_q[LS];
      det_out_q  <= det_q[LS];
    end
  end

  assign out_o.valid     = v_q[SOut];
  assign out_o.inv00     = inv_q[0];
  assign out_o.inv01     = inv_q[1];
  assign out_o.inv02     = inv_q[2];
  assign out_o.inv10     = inv_q[3];
  assign out_o.inv11     = inv_q[4];
  assign out_o.inv12     = inv_q[5];
  assign out_o.inv20     = inv_q[6];
  assign out_o.inv21     = inv_q[7];
  assign out_o.inv22     = inv_q[8];
  assign out_o.singular  = sing_out_q;
  assign out_o.det_value = det_out_q;

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.singular |-> out_o.det_value == '0 &&
      out_o.inv00 == '0 && out_o.inv11 == '0 && out_o.inv22 == '0)
    else $error("singular result carries nonzero fields");

  a_det_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.singular |-> out_o.det_value != '0)
    else $error("nonsingular result with zero determinant");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> v_q[0])
    else $error("accepted request did not enter the pipeline");

endmodule

/* tb/tb_mi3inv_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mi3inv_ifs
// Expected-result record shared by the testbench predictor and checker.
// ----------------------------------------------------------------------------
package tb_mi3inv_types;
  typedef struct {
    logic signed [31:0] inv [9];
    logic               singular;
    logic signed [48:0] det;
  } inverse_t;
endpackage

/* tb/tb_matrix3x3_inverse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse
// Streams 3x3 Q8.8 matrices into the inverse pipeline under random sender
// gaps and receiver stalls, predicts each determinant and saturated Q16.16
// inverse, and compares every result field in order.
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse;

  localparam int Latency = 40;
  localparam longint CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  mi3inv_in_if  req_if ();
  mi3inv_out_if res_if ();

  matrix3x3_inverse dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  tb_mi3inv_types::inverse_t expected_q[$];
  int         n_errors = 0;
  longint     cycle_cnt = 0;
  int         stall_mode = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    n_errors++;
  endtask

  function automatic tb_mi3inv_types::inverse_t predict_inverse(
      input logic signed [15:0] a [9]);
    tb_mi3inv_types::inverse_t r;
    longint m [9];
    longint cof [9];
    longint det, q;
    for (int k = 0; k < 9; k++) m[k] = a[k];
    cof[0] = m[4]*m[8] - m[5]*m[7];
    cof[1] = m[2]*m[7] - m[1]*m[8];
    cof[2] = m[1]*m[5] - m[2]*m[4];
    cof[3] = m[5]*m[6] - m[3]*m[8];
    cof[4] = m[0]*m[8] - m[2]*m[6];
    cof[5] = m[2]*m[3] - m[0]*m[5];
    cof[6] = m[3]*m[7] - m[4]*m[6];
    cof[7] = m[1]*m[6] - m[0]*m[7];
    cof[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
    r.singular = (det == 0);
    r.det = det[48:0];
    for (int k = 0; k < 9; k++) begin
      if (det == 0) begin
        r.inv[k] = '0;
      end else begin
        // |cof| < 2^33 so the scaled value fits in 64 bits; sv division truncates
        q = (cof[k] * 64'sd16777216) / det;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        r.inv[k] = q[31:0];
      end
    end
    return r;
  endfunction

  task automatic send_matrix(input logic signed [15:0] a [9]);
    req_if.valid <= 1'b1;
    {req_if.a00, req_if.a01, req_if.a02} <= {a[0], a[1], a[2]};
    {req_if.a10, req_if.a11, req_if.a12} <= {a[3], a[4], a[5]};
    {req_if.a20, req_if.a21, req_if.a22} <= {a[6], a[7], a[8]};
    do @(posedge clk_i); while (!req_if.ready);
    expected_q.push_back(predict_inverse(a));
    @(negedge clk_i);
  endtask

  // sender drops valid for an idle gap, between bursts and after the directed test
  task automatic idle_gap(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic test_directed();
    logic signed [15:0] a [9];
    // identity, diagonal
    a = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100}; send_matrix(a);
    a = '{16'sh0200, 0, 0, 0, -16'sh0400, 0, 0, 0, 16'sh0080}; send_matrix(a);
    // singular: zero matrix, repeated row, all ones
    a = '{default: 0}; send_matrix(a);
    a = '{1, 2, 3, 1, 2, 3, 7, -8, 9}; send_matrix(a);
    a = '{default: 16'sh0100}; send_matrix(a);
    // tiny determinant, then quotients that saturate both ways
    a = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
    a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
    a = '{1, 16'sh7fff, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
    a = '{1, 16'sh8000, 0, 0, 1, 0, 0, 0, 1}; send_matrix(a);
    // field extremes
    a = '{default: 16'sh8000}; send_matrix(a);
    a = '{default: 16'sh7fff}; send_matrix(a);
    a = '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh8000}; send_matrix(a);
    a = '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh8000, 16'sh8000, 16'sh7fff}; send_matrix(a);
    a = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(a);
    a = '{-1, -1, 0, 0, -1, -1, -1, 0, -1}; send_matrix(a);
    idle_gap(3);
  endtask

  task automatic test_random(input int n_items);
    logic signed [15:0] a [9];
    int burst;
    int sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < n_items; b++) begin
        for (int k = 0; k < 9; k++) begin
          case ($urandom_range(0, 5))
            0: a[k] = 16'($urandom);
            1: a[k] = $signed(16'($urandom_range(0, 8))) - 16'sd4;
            2: a[k] = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: a[k] = $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
          endcase
        end
        // make some singular by copying a row
        if ($urandom_range(0, 9) == 0) begin
          for (int c = 0; c < 3; c++) a[6+c] = a[c];
        end
        send_matrix(a);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 6));
    end
    req_if.valid <= 1'b0;
  endtask

  // receiver stall pattern: randomly picks free-running, random or periodic stalling spells
  always @(negedge clk_i) begin
    if (cycle_cnt % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: res_if.ready <= 1'b1;
      1: res_if.ready <= ($urandom_range(0, 3) != 0);
      default: res_if.ready <= (cycle_cnt % 7) < 3;
    endcase
  end

  always @(posedge clk_i) begin
    tb_mi3inv_types::inverse_t w;
    logic signed [31:0] got [9];
    cycle_cnt++;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.inv00, res_if.inv01, res_if.inv02, res_if.inv10, res_if.inv11,
              res_if.inv12, res_if.inv20, res_if.inv21, res_if.inv22};
      if (expected_q.size() == 0) begin
        $display("unexpected inverse at %0t", $time);
        n_errors++;
      end else begin
        w = expected_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (got[k] !== w.inv[k]) report($sformatf("inv%0d%0d", k/3, k%3), got[k], w.inv[k]);
        if (res_if.singular !== w.singular) report("singular", res_if.singular, w.singular);
        if (res_if.det_value !== w.det) report("det_value", res_if.det_value, w.det);
      end
    end
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    req_if.valid = 1'b0;
    {req_if.a00, req_if.a01, req_if.a02} = '0;
    {req_if.a10, req_if.a11, req_if.a12} = '0;
    {req_if.a20, req_if.a21, req_if.a22} = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(1500);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
